/* rtl/blle_pkg.sv */
// Shared types and constants for the bounded linked list engine.
// Holds request and status codes, the cell command set and the cell control bundle.
// No dependencies.
`default_nettype none

package blle_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 4;
	localparam int ST_W   = 2;
	localparam int LEN_W  = 6;

	typedef logic signed [DATA_W-1:0] data_t;

	// Request codes carried by req_type.
	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD   = 4'd0,
		OP_INS_TAIL   = 4'd1,
		OP_INS_AFTER  = 4'd2,
		OP_INS_BEFORE = 4'd3,
		OP_DEL_HEAD   = 4'd4,
		OP_DEL_TAIL   = 4'd5,
		OP_DEL_MATCH  = 4'd6,
		OP_EMIT_FWD   = 4'd7,
		OP_EMIT_BACK  = 4'd8,
		OP_REVERSE    = 4'd9
	} op_t;

	// Status codes returned with every result item.
	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Command broadcast to all cells of the chain in the same cycle.
	typedef enum logic [3:0] {
		CMD_HOLD,
		CMD_PUSH_HEAD,
		CMD_PUSH_TAIL,
		CMD_INS_AFTER,
		CMD_INS_BEFORE,
		CMD_POP_HEAD,
		CMD_POP_TAIL,
		CMD_DEL_MATCH,
		CMD_ROT_LEFT,
		CMD_ROT_RIGHT,
		CMD_REV_STEP
	} cmd_t;

	// Control bundle shared by all cells.
	typedef struct packed {
		cmd_t  cmd;
		data_t din;
		data_t key;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/blle_cell.sv */
// One cell of the list chain: holds one element position, ordered from the head.
// Exchanges value and valid with both neighbours and passes the key search flag on.
// Depends on blle_pkg.
`default_nettype none

module blle_cell #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire blle_pkg::cell_ctl_t ctl,
	input  wire logic [CW-1:0]       k,
	input  wire logic                left_v,
	input  wire blle_pkg::data_t     left_d,
	input  wire logic                left_hb,
	input  wire logic                left_past,
	input  wire logic                right_v,
	input  wire blle_pkg::data_t     right_d,
	output logic                     v,
	output blle_pkg::data_t          d,
	output logic                     hb,
	output logic                     past,
	output logic                     match,
	output logic                     tail
);
	import blle_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic  v_q;
	data_t d_q;
	logic  hb_q;
	logic  v_n;
	data_t d_n;
	logic  first;

	// Local view of the key search and of the tail position.
	assign match = v_q && (d_q == ctl.key);
	assign past  = hb_q || match;
	assign first = match && !hb_q;
	assign tail  = v_q && !right_v;
	assign v     = v_q;
	assign d     = d_q;
	assign hb    = hb_q;

	// Next contents of this position under the broadcast command.
	always_comb begin
		v_n = v_q;
		d_n = d_q;
		case (ctl.cmd)
			CMD_PUSH_HEAD: begin
				v_n = left_v;
				d_n = left_d;
			end
			CMD_PUSH_TAIL: begin
				if (!v_q && left_v) begin
					v_n = 1'b1;
					d_n = ctl.din;
				end
			end
			CMD_INS_AFTER: begin
				if (hb_q && !left_hb) begin
					v_n = 1'b1;
					d_n = ctl.din;
				end else if (left_hb) begin
					v_n = left_v;
					d_n = left_d;
				end
			end
			CMD_INS_BEFORE: begin
				if (first) begin
					d_n = ctl.din;
				end else if (hb_q) begin
					v_n = left_v;
					d_n = left_d;
				end
			end
			CMD_POP_HEAD: begin
				v_n = right_v;
				d_n = right_d;
			end
			CMD_POP_TAIL: begin
				if (tail) begin
					v_n = 1'b0;
				end
			end
			CMD_DEL_MATCH: begin
				if (past) begin
					v_n = right_v;
					d_n = right_d;
				end
			end
			CMD_ROT_LEFT: begin
				if (right_v) begin
					d_n = right_d;
				end else if (v_q) begin
					d_n = ctl.din;
				end
			end
			CMD_ROT_RIGHT: begin
				if (v_q) begin
					d_n = left_d;
				end
			end
			CMD_REV_STEP: begin
				if (k == MY_IDX) begin
					d_n = ctl.din;
				end else if (v_q && (k < MY_IDX)) begin
					d_n = left_d;
				end
			end
			default: begin
				v_n = v_q;
				d_n = d_q;
			end
		endcase
	end

	// Occupancy and search flag are control state; the value needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= 1'b0;
			hb_q <= 1'b0;
		end else begin
			v_q  <= v_n;
			hb_q <= left_past;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= d_n;
	end

endmodule

`default_nettype wire

/* rtl/bounded_linked_list_engine.sv */
// Top level of the bounded linked list engine: request control and the cell chain.
// Instantiates CAPACITY copies of blle_cell; depends on blle_pkg.
//
// Usage: requests arrive on in_valid/in_stall with req_type, value and key; results
// leave on out_valid/out_stall with status, element, last and length. An item is
// taken on a rising edge with valid high and stall low. One request is worked on at
// a time; in_stall is low only while the engine is idle, and a new request may be
// taken while the previous result still waits in the output register.
// The list is held in order from the head in a chain of cells, one element each.
// Inserts and deletes at head or tail, empty answers and reverse of a short list pass
// through the decide and result states, then load their result and return to idle.
// Keyed operations hold the chain in the search state while the match flag ripples
// down it, one cell a cycle, and then answer through the apply and result states.
// A traversal rotates the chain one place a cycle while the output register is free
// and gives one item per cycle under the same condition, from the head or the tail.
// Reverse moves the tail value into each position in turn from the head, then answers.
// Reset empties the list at once. A stalled output holds its item; traversals then
// pause with the chain until the output register frees.
`default_nettype none

module bounded_linked_list_engine #(
	parameter int CAPACITY = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [blle_pkg::OP_W-1:0]     req_type,
	input  wire logic signed [blle_pkg::DATA_W-1:0] value,
	input  wire logic signed [blle_pkg::DATA_W-1:0] key,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [blle_pkg::ST_W-1:0]          status,
	output logic signed [blle_pkg::DATA_W-1:0] element,
	output logic                               last,
	output logic [blle_pkg::LEN_W-1:0]         length
);
	import blle_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
	localparam logic [CW-1:0] SRCH_END = CW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SEARCH,
		S_APPLY,
		S_WALK,
		S_REV,
		S_RESULT
	} state_t;

	state_t    state_q;
	op_t       op_q;
	data_t     val_q;
	data_t     key_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	status_t   res_st_q;
	data_t     res_el_q;
	logic      out_valid_q;
	status_t   status_q;
	data_t     element_q;
	logic      last_q;
	logic [LEN_W-1:0] length_q;

	cell_ctl_t ctl;
	logic      full;
	logic      empty;
	logic      out_free;
	logic      out_load;
	logic      any_match;
	logic      walk_last;
	data_t     head_d;
	data_t     tail_d;

	logic  [CAPACITY-1:0] v_vec;
	logic  [CAPACITY-1:0] hb_vec;
	logic  [CAPACITY-1:0] past_vec;
	logic  [CAPACITY-1:0] match_vec;
	logic  [CAPACITY-1:0] tail_vec;
	data_t                d_arr [CAPACITY];

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;
	assign length    = length_q;

	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == S_WALK) || (state_q == S_RESULT)) && out_free;
	assign any_match = |match_vec;
	assign head_d    = d_arr[0];
	assign walk_last = (k_q == (count_q - CW'(1)));

	// Tail value: the one valid cell whose right neighbour is empty.
	always_comb begin
		tail_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail_d = tail_d | ({DATA_W{tail_vec[i]}} & d_arr[i]);
		end
	end

	// Command and broadcast data for the chain in this cycle.
	always_comb begin
		ctl.cmd = CMD_HOLD;
		ctl.key = key_q;
		case (state_q)
			S_DECIDE: begin
				case (op_q)
					OP_INS_HEAD: if (!full) ctl.cmd = CMD_PUSH_HEAD;
					OP_INS_TAIL: if (!full) ctl.cmd = CMD_PUSH_TAIL;
					OP_DEL_HEAD: if (!empty) ctl.cmd = CMD_POP_HEAD;
					OP_DEL_TAIL: if (!empty) ctl.cmd = CMD_POP_TAIL;
					default: ctl.cmd = CMD_HOLD;
				endcase
			end
			S_APPLY: begin
				if (any_match) begin
					case (op_q)
						OP_INS_AFTER: if (!full) ctl.cmd = CMD_INS_AFTER;
						OP_INS_BEFORE: if (!full) ctl.cmd = CMD_INS_BEFORE;
						OP_DEL_MATCH: ctl.cmd = CMD_DEL_MATCH;
						default: ctl.cmd = CMD_HOLD;
					endcase
				end
			end
			S_WALK: begin
				if (out_free) begin
					ctl.cmd = (op_q == OP_EMIT_FWD) ? CMD_ROT_LEFT : CMD_ROT_RIGHT;
				end
			end
			S_REV: begin
				ctl.cmd = CMD_REV_STEP;
			end
			default: ctl.cmd = CMD_HOLD;
		endcase
		case (ctl.cmd)
			CMD_ROT_LEFT: ctl.din = head_d;
			CMD_ROT_RIGHT, CMD_REV_STEP: ctl.din = tail_d;
			default: ctl.din = val_q;
		endcase
	end

	// The chain of cells, head at index zero.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic  lv;
		data_t ld;
		logic  lhb;
		logic  lpast;
		logic  rv;
		data_t rd;

		if (i == 0) begin : g_first
			assign lv    = 1'b1;
			assign ld    = ctl.din;
			assign lhb   = 1'b0;
			assign lpast = 1'b0;
		end else begin : g_inner_l
			assign lv    = v_vec[i-1];
			assign ld    = d_arr[i-1];
			assign lhb   = hb_vec[i-1];
			assign lpast = past_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_inner_r
			assign rv = v_vec[i+1];
			assign rd = d_arr[i+1];
		end

		blle_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.k         (k_q),
			.left_v    (lv),
			.left_d    (ld),
			.left_hb   (lhb),
			.left_past (lpast),
			.right_v   (rv),
			.right_d   (rd),
			.v         (v_vec[i]),
			.d         (d_arr[i]),
			.hb        (hb_vec[i]),
			.past      (past_vec[i]),
			.match     (match_vec[i]),
			.tail      (tail_vec[i])
		);
	end

	// Request sequencer, element count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			op_q        <= OP_INS_HEAD;
			val_q       <= '0;
			key_q       <= '0;
			k_q         <= '0;
			res_st_q    <= ST_OK;
			res_el_q    <= '0;
			status_q    <= ST_OK;
			element_q   <= '0;
			last_q      <= 1'b0;
			length_q    <= '0;
		end else begin
			// The output item stays until taken; a new one is loaded when the register frees.
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(req_type);
						val_q   <= value;
						key_q   <= key;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					k_q <= '0;
					case (op_q)
						OP_INS_HEAD, OP_INS_TAIL: begin
							res_el_q <= '0;
							state_q  <= S_RESULT;
							if (full) begin
								res_st_q <= ST_FULL;
							end else begin
								res_st_q <= ST_OK;
								count_q  <= count_q + CW'(1);
							end
						end
						OP_INS_AFTER, OP_INS_BEFORE, OP_DEL_MATCH: begin
							res_el_q <= '0;
							if (empty) begin
								res_st_q <= ST_EMPTY;
								state_q  <= S_RESULT;
							end else begin
								res_st_q <= ST_OK;
								state_q  <= S_SEARCH;
							end
						end
						OP_DEL_HEAD: begin
							state_q <= S_RESULT;
							if (empty) begin
								res_st_q <= ST_EMPTY;
								res_el_q <= '0;
							end else begin
								res_st_q <= ST_OK;
								res_el_q <= head_d;
								count_q  <= count_q - CW'(1);
							end
						end
						OP_DEL_TAIL: begin
							state_q <= S_RESULT;
							if (empty) begin
								res_st_q <= ST_EMPTY;
								res_el_q <= '0;
							end else begin
								res_st_q <= ST_OK;
								res_el_q <= tail_d;
								count_q  <= count_q - CW'(1);
							end
						end
						OP_EMIT_FWD, OP_EMIT_BACK: begin
							res_el_q <= '0;
							if (empty) begin
								res_st_q <= ST_EMPTY;
								state_q  <= S_RESULT;
							end else begin
								res_st_q <= ST_OK;
								state_q  <= S_WALK;
							end
						end
						OP_REVERSE: begin
							res_st_q <= ST_OK;
							res_el_q <= '0;
							if (count_q > CW'(1)) begin
								state_q <= S_REV;
							end else begin
								state_q <= S_RESULT;
							end
						end
						default: begin
							res_st_q <= ST_OK;
							res_el_q <= '0;
							state_q  <= S_RESULT;
						end
					endcase
				end
				S_SEARCH: begin
					// Let the match flag ripple to the far end of the chain.
					k_q <= k_q + CW'(1);
					if (k_q == SRCH_END) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_RESULT;
					if (!any_match) begin
						res_st_q <= ST_NOTFOUND;
					end else if (op_q == OP_DEL_MATCH) begin
						res_el_q <= key_q;
						count_q  <= count_q - CW'(1);
					end else if (full) begin
						res_st_q <= ST_FULL;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				S_WALK: begin
					// One element per cycle while the output register is free.
					if (out_free) begin
						status_q    <= ST_OK;
						element_q   <= (op_q == OP_EMIT_FWD) ? head_d : tail_d;
						last_q      <= walk_last;
						length_q    <= LEN_W'(count_q);
						k_q         <= k_q + CW'(1);
						if (walk_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_REV: begin
					k_q <= k_q + CW'(1);
					if (k_q == (count_q - CW'(2))) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						status_q    <= res_st_q;
						element_q   <= res_el_q;
						last_q      <= 1'b1;
						length_q    <= LEN_W'(count_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
